FILE: sv/sit_pkg.sv
// Shared types and codes for the sorted insertion table.
// No dependencies; used by sit_cell and sorted_insertion_table.
package sit_pkg;

   localparam int KEY_W    = 63;
   localparam int TAG_W    = 16;
   localparam int STATUS_W = 2;

   // Command codes of a request word
   typedef enum logic [0:0] {
      CMD_INSERT = 1'b0,
      CMD_DRAIN  = 1'b1
   } cmd_type;

   // Status codes of a response word
   typedef enum logic [STATUS_W-1:0] {
      STATUS_ACCEPTED = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_DRAINED  = 2'd2
   } status_type;

   typedef struct packed {
      logic [0:0]       cmd;
      logic [KEY_W-1:0] size_key;
      logic [TAG_W-1:0] tag;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [KEY_W-1:0]    out_key;
      logic [TAG_W-1:0]    out_tag;
      logic                out_valid;
      logic                last;
   } rsp_type;

   // One stored entry
   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] tag;
   } entry_type;

   // Per-cycle control broadcast to every cell
   typedef struct packed {
      logic insert;
      logic shift_down;
   } cell_ctrl_type;

endpackage

FILE: sv/sit_cell.sv
// One cell of the sorted chain: holds a single entry and its key compare.
// Depends on sit_pkg for entry and control types.
module sit_cell (
   input  logic                   clock,
   input  sit_pkg::cell_ctrl_type ctrl,
   input  sit_pkg::entry_type     new_entry,
   input  sit_pkg::entry_type     left_entry,
   input  logic                   left_gt,
   input  sit_pkg::entry_type     right_entry,
   input  logic                   occupied,
   input  logic                   tail,
   output sit_pkg::entry_type     entry,
   output logic                   gt
);

   sit_pkg::entry_type entry_ff;
   sit_pkg::entry_type entry_in;

   // Stored key strictly above the new key: this cell moves up on insert
   assign gt = occupied && (entry_ff.key > new_entry.key);

   // Select the next entry: pull from above on drain, push up on insert
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.shift_down) begin
         entry_in = right_entry;
      end else if (ctrl.insert && (gt || tail)) begin
         entry_in = left_gt ? left_entry : new_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

FILE: sv/sorted_insertion_table.sv
// Top level of the sorted insertion table: control, fill count, response register.
// Depends on sit_pkg and sit_cell.
//
//   channel  direction  handshake        payload
//   req      in         req_valid/stall  sit_pkg::req_type
//   rsp      out        rsp_valid/stall  sit_pkg::rsp_type
//
// On an insert, every cell compares against the new key at once
// and the cells above the insertion point shift up together.
// A drain shifts entries down the chain into the response register, one entry per
// cycle while the response is not stalled; an empty drain gives a single status word.
// Reset clears the fill count, the drain state and the response valid; cell contents are not reset.
// req_stall is high during a drain and whenever the response register is full
// and stalled; a stalled response holds its word.
module sorted_insertion_table #(
   parameter int DEPTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sit_pkg::req_type req_word,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sit_pkg::rsp_type rsp_word
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             draining_ff, draining_in;
   logic             rsp_valid_ff, rsp_valid_in;
   sit_pkg::rsp_type rsp_word_ff, rsp_word_in;

   sit_pkg::cell_ctrl_type ctrl;
   sit_pkg::entry_type     new_entry;
   sit_pkg::entry_type     cell_entry [DEPTH];
   logic [DEPTH-1:0]       cell_gt;

   logic out_free, req_take, full, is_insert, start_drain, emit_entry, last_entry;

   // Handshake and decode
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign req_stall   = draining_ff || !out_free;
   assign req_take    = req_valid && !req_stall;
   assign full        = (count_ff == CNT_W'(DEPTH));
   assign is_insert   = (req_word.cmd == sit_pkg::CMD_INSERT);
   assign start_drain = req_take && !is_insert;
   assign emit_entry  = (draining_ff && out_free) || (start_drain && (count_ff != '0));
   assign last_entry  = (count_ff == CNT_W'(1));

   assign ctrl.insert     = req_take && is_insert && !full;
   assign ctrl.shift_down = emit_entry;
   assign new_entry.key   = req_word.size_key;
   assign new_entry.tag   = req_word.tag;

   // Chain of cells, lowest key at cell zero
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      sit_pkg::entry_type left_e, right_e;
      logic               left_g;
      if (i == 0) begin : g_first
         assign left_e = new_entry;
         assign left_g = 1'b0;
      end else begin : g_mid
         assign left_e = cell_entry[i-1];
         assign left_g = cell_gt[i-1];
      end
      if (i == DEPTH - 1) begin : g_end
         assign right_e = cell_entry[i];
      end else begin : g_inner
         assign right_e = cell_entry[i+1];
      end
      sit_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .new_entry   (new_entry),
         .left_entry  (left_e),
         .left_gt     (left_g),
         .right_entry (right_e),
         .occupied    (CNT_W'(i) < count_ff),
         .tail        (CNT_W'(i) == count_ff),
         .entry       (cell_entry[i]),
         .gt          (cell_gt[i])
      );
   end

   // Advance count, drain state and response register
   always_comb begin
      count_in     = count_ff;
      draining_in  = draining_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (ctrl.insert) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (emit_entry) begin
         count_in              = count_ff - CNT_W'(1);
         draining_in           = !last_entry;
         rsp_valid_in          = 1'b1;
         rsp_word_in.status    = sit_pkg::STATUS_DRAINED;
         rsp_word_in.out_key   = cell_entry[0].key;
         rsp_word_in.out_tag   = cell_entry[0].tag;
         rsp_word_in.out_valid = 1'b1;
         rsp_word_in.last      = last_entry;
      end else if (req_take) begin
         rsp_valid_in          = 1'b1;
         rsp_word_in.out_key   = '0;
         rsp_word_in.out_tag   = '0;
         rsp_word_in.out_valid = 1'b0;
         rsp_word_in.last      = 1'b1;
         if (!is_insert) begin
            rsp_word_in.status = sit_pkg::STATUS_DRAINED;
         end else if (full) begin
            rsp_word_in.status = sit_pkg::STATUS_FULL;
         end else begin
            rsp_word_in.status = sit_pkg::STATUS_ACCEPTED;
         end
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         draining_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         draining_ff  <= draining_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

`ifndef ASSERT_OFF
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("fill count above depth");

   a_drain_nonempty: assert property (@(posedge clock) disable iff (reset)
      draining_ff |-> (count_ff != '0))
      else $error("drain in progress with empty table");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      ctrl.insert |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("insert did not grow the table");

   a_mid_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_word_ff.last) |-> draining_ff)
      else $error("non-final response outside a drain");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_word_ff.status != sit_pkg::STATUS_DRAINED))
         |-> rsp_word_ff.last)
      else $error("status response not marked last");
`endif

endmodule
